// ===== hw/rtl/rainbow_pixel_color_generator_assert.svh =====
// Assertion macros shared by the rainbow pixel color generator modules.
`ifndef RAINBOW_PIXEL_COLOR_GENERATOR_ASSERT_SVH
`define RAINBOW_PIXEL_COLOR_GENERATOR_ASSERT_SVH

// Implication in the same cycle, checked on every clock edge outside reset.
`define RPCG_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Implication in the next cycle.
`define RPCG_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/rpcg_pkg.sv =====
// Types, constants and codes shared by the rainbow pixel color generator.
`timescale 1ns / 1ps

package rpcg_pkg;

  localparam int MAX_LEDS    = 1024;
  localparam int IDX_W       = 10;
  localparam int LEN_W       = 11;
  localparam int HUE_W       = 9;
  localparam int COLOR_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int HUE_RANGE   = 360;
  localparam int SECTOR_DEG  = 60;
  localparam int FULL_SCALE  = 255;
  // Widest chase dividend: 1023 * 360 fits in 19 bits.
  localparam int DIVIDEND_W  = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_SPEED        = 3'd1,
    REG_STRIP_LENGTH = 3'd2,
    REG_SATURATION   = 3'd3,
    REG_BRIGHTNESS   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HSV,
    ST_HOLD
  } state_t;

  typedef enum logic [2:0] {
    SEC_R_TO_Y,
    SEC_Y_TO_G,
    SEC_G_TO_C,
    SEC_C_TO_B,
    SEC_B_TO_M,
    SEC_M_TO_R
  } sector_t;

  typedef struct packed {
    logic [IDX_W-1:0] led_index;
    logic             frame_end;
  } pix_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [HUE_W-1:0]   pixel_hue;
  } color_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [COLOR_W-1:0] sat;
    logic [COLOR_W-1:0] val;
  } hsv_in_t;

endpackage

// ===== hw/rtl/rpcg_serial_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

`include "rainbow_pixel_color_generator_assert.svh"

module rpcg_serial_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [rpcg_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [rpcg_pkg::LEN_W-1:0]       divisor,
  output logic                             done,
  output logic [rpcg_pkg::HUE_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(rpcg_pkg::DIVIDEND_W + 1);

  logic                            busy;
  logic [CNT_W-1:0]                cnt;
  logic [rpcg_pkg::LEN_W-1:0]      rem;
  logic [rpcg_pkg::LEN_W-1:0]      divisor_r;
  // Dividend bits shift out at the top while quotient bits shift in below.
  logic [rpcg_pkg::DIVIDEND_W-1:0] qd;
  logic [rpcg_pkg::LEN_W:0]        trial;
  logic                            fits;

  assign trial    = {rem, qd[rpcg_pkg::DIVIDEND_W-1]};
  assign fits     = trial >= {1'b0, divisor_r};
  assign quotient = qd[rpcg_pkg::HUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(rpcg_pkg::DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= '0;
      qd        <= dividend;
      divisor_r <= divisor;
    end else if (busy) begin
      rem <= fits ? rpcg_pkg::LEN_W'(trial - {1'b0, divisor_r}) : trial[rpcg_pkg::LEN_W-1:0];
      qd  <= {qd[rpcg_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  `RPCG_ASSERT_IMP(a_rem_below_divisor, busy, rem < divisor_r, "remainder not below divisor")
  `RPCG_ASSERT_NXT(a_start_runs, start, busy, "divider did not start")
  `RPCG_ASSERT_IMP(a_done_idle, done, !busy, "divider done while still busy")

endmodule

// ===== hw/rtl/rpcg_hsv.sv =====
// Three-stage integer HSV to RGB converter over six hue sectors.
`timescale 1ns / 1ps

module rpcg_hsv (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rpcg_pkg::hsv_in_t hsv,
  output logic              out_valid,
  output rpcg_pkg::color_t  rgb
);

  localparam int CW = rpcg_pkg::COLOR_W;
  localparam int HW = rpcg_pkg::HUE_W;
  localparam logic [CW-1:0] FULL = CW'(rpcg_pkg::FULL_SCALE);

  // Stage A: sector and scaled remainder.
  rpcg_pkg::sector_t sector_c;
  logic [HW-1:0]     rem_deg;
  logic [CW+1:0]     rem_x17;
  logic              valid_a;
  rpcg_pkg::sector_t sector_a;
  logic [CW-1:0]     rem_a;
  logic [CW-1:0]     sat_a;
  logic [CW-1:0]     val_a;
  logic [HW-1:0]     hue_a;

  // Stage B: saturation terms.
  logic [2*CW-1:0]   prod_q;
  logic [2*CW-1:0]   prod_t;
  logic              valid_b;
  rpcg_pkg::sector_t sector_b;
  logic [CW-1:0]     term_q;
  logic [CW-1:0]     term_t;
  logic [CW-1:0]     term_p;
  logic [CW-1:0]     val_b;
  logic [HW-1:0]     hue_b;

  // Stage C: value products and channel selection.
  logic [2*CW-1:0]   prod_p2;
  logic [2*CW-1:0]   prod_q2;
  logic [2*CW-1:0]   prod_t2;
  logic [CW-1:0]     p;
  logic [CW-1:0]     q;
  logic [CW-1:0]     t;
  rpcg_pkg::color_t  rgb_c;

  always_comb begin
    sector_c = rpcg_pkg::SEC_R_TO_Y;
    rem_deg  = hsv.hue;
    if (hsv.hue >= HW'(5 * rpcg_pkg::SECTOR_DEG)) begin
      sector_c = rpcg_pkg::SEC_M_TO_R;
      rem_deg  = hsv.hue - HW'(5 * rpcg_pkg::SECTOR_DEG);
    end else if (hsv.hue >= HW'(4 * rpcg_pkg::SECTOR_DEG)) begin
      sector_c = rpcg_pkg::SEC_B_TO_M;
      rem_deg  = hsv.hue - HW'(4 * rpcg_pkg::SECTOR_DEG);
    end else if (hsv.hue >= HW'(3 * rpcg_pkg::SECTOR_DEG)) begin
      sector_c = rpcg_pkg::SEC_C_TO_B;
      rem_deg  = hsv.hue - HW'(3 * rpcg_pkg::SECTOR_DEG);
    end else if (hsv.hue >= HW'(2 * rpcg_pkg::SECTOR_DEG)) begin
      sector_c = rpcg_pkg::SEC_G_TO_C;
      rem_deg  = hsv.hue - HW'(2 * rpcg_pkg::SECTOR_DEG);
    end else if (hsv.hue >= HW'(rpcg_pkg::SECTOR_DEG)) begin
      sector_c = rpcg_pkg::SEC_Y_TO_G;
      rem_deg  = hsv.hue - HW'(rpcg_pkg::SECTOR_DEG);
    end
  end

  // 255/60 is exactly 17/4, so the scaled remainder is (rem * 17) >> 2.
  assign rem_x17 = (CW+2)'(rem_deg) * (CW+2)'(17);

  assign prod_q  = (2*CW)'(sat_a) * (2*CW)'(rem_a);
  assign prod_t  = (2*CW)'(sat_a) * (2*CW)'(FULL - rem_a);

  assign prod_p2 = (2*CW)'(val_b) * (2*CW)'(term_p);
  assign prod_q2 = (2*CW)'(val_b) * (2*CW)'(term_q);
  assign prod_t2 = (2*CW)'(val_b) * (2*CW)'(term_t);
  assign p = prod_p2[2*CW-1:CW];
  assign q = prod_q2[2*CW-1:CW];
  assign t = prod_t2[2*CW-1:CW];

  always_comb begin
    rgb_c.pixel_hue = hue_b;
    case (sector_b)
      rpcg_pkg::SEC_R_TO_Y: begin
        rgb_c.red = val_b; rgb_c.green = t; rgb_c.blue = p;
      end
      rpcg_pkg::SEC_Y_TO_G: begin
        rgb_c.red = q; rgb_c.green = val_b; rgb_c.blue = p;
      end
      rpcg_pkg::SEC_G_TO_C: begin
        rgb_c.red = p; rgb_c.green = val_b; rgb_c.blue = t;
      end
      rpcg_pkg::SEC_C_TO_B: begin
        rgb_c.red = p; rgb_c.green = q; rgb_c.blue = val_b;
      end
      rpcg_pkg::SEC_B_TO_M: begin
        rgb_c.red = t; rgb_c.green = p; rgb_c.blue = val_b;
      end
      default: begin
        rgb_c.red = val_b; rgb_c.green = p; rgb_c.blue = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      sector_a <= sector_c;
      rem_a    <= rem_x17[CW+1:2];
      sat_a    <= hsv.sat;
      val_a    <= hsv.val;
      hue_a    <= hsv.hue;
    end
    if (valid_a) begin
      sector_b <= sector_a;
      term_q   <= FULL - prod_q[2*CW-1:CW];
      term_t   <= FULL - prod_t[2*CW-1:CW];
      term_p   <= FULL - sat_a;
      val_b    <= val_a;
      hue_b    <= hue_a;
    end
    if (valid_b) begin
      rgb <= rgb_c;
    end
  end

endmodule

// ===== hw/rtl/rainbow_pixel_color_generator.sv =====
// Top level of the rainbow pixel color generator: registers, sequencing and hue offset.
//
//   channel  direction  handshake                payload
//   pix      in         pix_valid / pix_ready    rpcg_pkg::pix_t (led_index, frame_end)
//   color    out        color_valid / color_ready rpcg_pkg::color_t (red, green, blue, pixel_hue)
//   cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A request passes from acceptance to color_valid through the serial divider
// (one quotient bit per cycle), the hue add register, three HSV stages and the
// output register.
// One request is in flight at a time; the next is accepted once the result is in the
// output register, even while that result still waits for color_ready.
// A stalled output holds the finished color inside the converter until the register frees.
// Reset is synchronous and returns the registers to their defaults and the offset to zero.
`timescale 1ns / 1ps

`include "rainbow_pixel_color_generator_assert.svh"

module rainbow_pixel_color_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  output logic                               pix_ready,
  input  rpcg_pkg::pix_t                     pix,
  output logic                               color_valid,
  input  logic                               color_ready,
  output rpcg_pkg::color_t                   color,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rpcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpcg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int HW = rpcg_pkg::HUE_W;
  localparam int LW = rpcg_pkg::LEN_W;
  localparam int CW = rpcg_pkg::COLOR_W;

  logic                  mode;
  logic [CW-1:0]         speed;
  logic [LW-1:0]         strip_length;
  logic [CW-1:0]         saturation;
  logic [CW-1:0]         brightness;
  logic [HW-1:0]         hue_base;
  logic [HW-1:0]         hue_base_next;

  rpcg_pkg::state_t      state;
  rpcg_pkg::state_t      state_next;
  logic                  accept;
  logic                  out_load;
  logic                  frame_end;

  logic [LW-1:0]         strip_eff;
  logic [LW-1:0]         idx_ext;
  logic [LW-1:0]         idx_clamp;
  logic [rpcg_pkg::DIVIDEND_W-1:0] dividend;
  logic                  div_done;
  logic [HW-1:0]         quotient;

  logic [HW:0]           hue_sum;
  logic [HW:0]           adv;
  rpcg_pkg::hsv_in_t     hsv_in;
  logic                  hue_valid;
  logic                  hsv_done;
  rpcg_pkg::color_t      hsv_rgb;

  assign cfg_ready = 1'b1;
  assign accept    = pix_valid && pix_ready;
  assign pix_ready = (state == rpcg_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      speed        <= CW'(1);
      strip_length <= LW'(60);
      saturation   <= CW'(rpcg_pkg::FULL_SCALE);
      brightness   <= CW'(rpcg_pkg::FULL_SCALE);
    end else if (cfg_valid) begin
      case (cfg_index)
        rpcg_pkg::REG_MODE:         mode         <= cfg_data[0];
        rpcg_pkg::REG_SPEED:        speed        <= cfg_data[CW-1:0];
        rpcg_pkg::REG_STRIP_LENGTH: strip_length <= cfg_data[LW-1:0];
        rpcg_pkg::REG_SATURATION:   saturation   <= cfg_data[CW-1:0];
        rpcg_pkg::REG_BRIGHTNESS:   brightness   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // A zero length counts as one LED; lengths past the maximum saturate.
  always_comb begin
    if (strip_length == '0) begin
      strip_eff = LW'(1);
    end else if (int'(strip_length) > rpcg_pkg::MAX_LEDS) begin
      strip_eff = LW'(rpcg_pkg::MAX_LEDS);
    end else begin
      strip_eff = strip_length;
    end
  end

  assign idx_ext   = LW'(pix.led_index);
  assign idx_clamp = (idx_ext >= strip_eff) ? strip_eff - LW'(1) : idx_ext;
  assign dividend  = rpcg_pkg::DIVIDEND_W'(idx_clamp) *
                     rpcg_pkg::DIVIDEND_W'(rpcg_pkg::HUE_RANGE);

  rpcg_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (dividend),
    .divisor  (strip_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  assign hue_sum = (mode ? '0 : {1'b0, quotient}) + {1'b0, hue_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_valid <= 1'b0;
    end else begin
      hue_valid <= div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_end <= pix.frame_end;
    end
    if (div_done) begin
      hsv_in.hue <= (hue_sum >= (HW+1)'(rpcg_pkg::HUE_RANGE)) ?
                    HW'(hue_sum - (HW+1)'(rpcg_pkg::HUE_RANGE)) : hue_sum[HW-1:0];
      hsv_in.sat <= saturation;
      hsv_in.val <= brightness;
    end
  end

  rpcg_hsv u_hsv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hue_valid),
    .hsv       (hsv_in),
    .out_valid (hsv_done),
    .rgb       (hsv_rgb)
  );

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      rpcg_pkg::ST_IDLE: begin
        if (pix_valid) state_next = rpcg_pkg::ST_DIV;
      end
      rpcg_pkg::ST_DIV: begin
        if (div_done) state_next = rpcg_pkg::ST_HSV;
      end
      rpcg_pkg::ST_HSV: begin
        if (hsv_done) begin
          if (!color_valid || color_ready) begin
            out_load   = 1'b1;
            state_next = rpcg_pkg::ST_IDLE;
          end else begin
            state_next = rpcg_pkg::ST_HOLD;
          end
        end
      end
      rpcg_pkg::ST_HOLD: begin
        if (!color_valid || color_ready) begin
          out_load   = 1'b1;
          state_next = rpcg_pkg::ST_IDLE;
        end
      end
      default: state_next = rpcg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpcg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Chase snaps the offset back to zero at a full turn; cycle wraps it around.
  assign adv = {1'b0, hue_base} + (HW+1)'(speed);
  always_comb begin
    if (adv < (HW+1)'(rpcg_pkg::HUE_RANGE)) begin
      hue_base_next = adv[HW-1:0];
    end else if (!mode) begin
      hue_base_next = '0;
    end else begin
      hue_base_next = HW'(adv - (HW+1)'(rpcg_pkg::HUE_RANGE));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_base    <= '0;
      color_valid <= 1'b0;
    end else begin
      if (out_load && frame_end) begin
        hue_base <= hue_base_next;
      end
      if (out_load) begin
        color_valid <= 1'b1;
      end else if (color_ready) begin
        color_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      color <= hsv_rgb;
    end
  end

  `RPCG_ASSERT_IMP(a_div_done_in_div, div_done, state == rpcg_pkg::ST_DIV, "late divide")
  `RPCG_ASSERT_IMP(a_hsv_done_in_hsv, hsv_done, state == rpcg_pkg::ST_HSV, "late convert")
  `RPCG_ASSERT_IMP(a_offset_range, 1'b1, hue_base < HW'(rpcg_pkg::HUE_RANGE), "bad offset")
  `RPCG_ASSERT_NXT(a_accept_divides, accept, state == rpcg_pkg::ST_DIV, "no divide")

endmodule

// ===== bench/tb_rainbow_pixel_color_generator.sv =====
// Self-checking bench for the rainbow pixel color generator: directed table, then random frames.
`timescale 1ns / 1ps

module tb_rainbow_pixel_color_generator;

  localparam int CW              = rpcg_pkg::COLOR_W;
  localparam int HW              = rpcg_pkg::HUE_W;
  localparam int IW              = rpcg_pkg::IDX_W;
  localparam int LW              = rpcg_pkg::LEN_W;
  localparam int XW              = rpcg_pkg::CFG_IDX_W;
  localparam int DW              = rpcg_pkg::CFG_DATA_W;
  localparam int FRAC_SHIFT      = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 60;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int MAX_PRINTS      = 40;
  localparam int LEN_ALL_ONES    = (1 << LW) - 1;
  localparam int DATA_ALL_ONES   = (1 << DW) - 1;

  localparam logic MODE_CHASE = 1'b0;
  localparam logic MODE_CYCLE = 1'b1;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [XW-1:0] REG_SPARE = 3'd5;
  localparam logic [XW-1:0] REG_TOP   = 3'd7;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [XW-1:0]     reg_idx;
    logic [DW-1:0]     data;
    rpcg_pkg::pix_t    px;
    bit                typed;
    rpcg_pkg::color_t  want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   pix_valid = 1'b0;
  logic                   pix_ready;
  rpcg_pkg::pix_t         pix = '0;
  logic                   color_valid;
  logic                   color_ready = 1'b0;
  rpcg_pkg::color_t       color;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [XW-1:0]          cfg_index = '0;
  logic [DW-1:0]          cfg_data = '0;

  // Shadow copy of the block's registers and hue offset.
  logic                cur_mode;
  logic [7:0]          cur_speed;
  logic [LW-1:0]       cur_len;
  logic [7:0]          cur_sat;
  logic [7:0]          cur_val;
  int unsigned         hue_ofs;

  row_t              plan[$];
  rpcg_pkg::color_t  pending_colors[$];
  rpcg_pkg::color_t  oldest;
  int unsigned errors = 0;
  int unsigned colors_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_style = 0;
  int unsigned stall_left = 0;

  rainbow_pixel_color_generator dut (
    .clk         (clk),
    .rst         (rst),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix         (pix),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .color       (color),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void reset_model();
    cur_mode  = MODE_CHASE;
    cur_speed = 8'd1;
    cur_len   = LW'(60);
    cur_sat   = 8'hFF;
    cur_val   = 8'hFF;
    hue_ofs   = 0;
  endfunction

  function automatic void apply_reg(logic [XW-1:0] idx, logic [DW-1:0] data);
    case (rpcg_pkg::cfg_reg_t'(idx))
      rpcg_pkg::REG_MODE:         cur_mode  = data[0];
      rpcg_pkg::REG_SPEED:        cur_speed = data[7:0];
      rpcg_pkg::REG_STRIP_LENGTH: cur_len   = data[LW-1:0];
      rpcg_pkg::REG_SATURATION:   cur_sat   = data[7:0];
      rpcg_pkg::REG_BRIGHTNESS:   cur_val   = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned usable_length();
    int unsigned n;
    n = 32'(cur_len);
    if (n == 0) n = 1;
    if (n > rpcg_pkg::MAX_LEDS) n = rpcg_pkg::MAX_LEDS;
    return n;
  endfunction

  // Color for one request, then the offset step when the request closes a frame.
  function automatic rpcg_pkg::color_t predict_pixel_color(rpcg_pkg::pix_t p);
    int unsigned n, idx, hue, s, v, rem, lo, fall, rise, nxt;
    rpcg_pkg::color_t c;
    n   = usable_length();
    idx = 32'(p.led_index);
    if (idx >= n) idx = n - 1;
    if (cur_mode == MODE_CHASE)
      hue = (idx * rpcg_pkg::HUE_RANGE / n + hue_ofs) % rpcg_pkg::HUE_RANGE;
    else
      hue = hue_ofs % rpcg_pkg::HUE_RANGE;
    s    = 32'(cur_sat);
    v    = 32'(cur_val);
    rem  = ((hue % rpcg_pkg::SECTOR_DEG) * rpcg_pkg::FULL_SCALE) / rpcg_pkg::SECTOR_DEG;
    lo   = (v * (rpcg_pkg::FULL_SCALE - s)) >> FRAC_SHIFT;
    fall = (v * (rpcg_pkg::FULL_SCALE - ((s * rem) >> FRAC_SHIFT))) >> FRAC_SHIFT;
    rise = (v * (rpcg_pkg::FULL_SCALE - ((s * (rpcg_pkg::FULL_SCALE - rem)) >> FRAC_SHIFT)))
           >> FRAC_SHIFT;
    case (rpcg_pkg::sector_t'(hue / rpcg_pkg::SECTOR_DEG))
      rpcg_pkg::SEC_R_TO_Y: begin c.red = CW'(v);    c.green = CW'(rise); c.blue = CW'(lo);   end
      rpcg_pkg::SEC_Y_TO_G: begin c.red = CW'(fall); c.green = CW'(v);    c.blue = CW'(lo);   end
      rpcg_pkg::SEC_G_TO_C: begin c.red = CW'(lo);   c.green = CW'(v);    c.blue = CW'(rise); end
      rpcg_pkg::SEC_C_TO_B: begin c.red = CW'(lo);   c.green = CW'(fall); c.blue = CW'(v);    end
      rpcg_pkg::SEC_B_TO_M: begin c.red = CW'(rise); c.green = CW'(lo);   c.blue = CW'(v);    end
      default:              begin c.red = CW'(v);    c.green = CW'(lo);   c.blue = CW'(fall); end
    endcase
    c.pixel_hue = hue[HW-1:0];
    if (p.frame_end) begin
      nxt = hue_ofs + 32'(cur_speed);
      // Chase snaps back to zero instead of wrapping; cycle wraps around.
      if (cur_mode == MODE_CHASE) begin
        if (nxt >= rpcg_pkg::HUE_RANGE) nxt = 0;
      end else begin
        nxt = nxt % rpcg_pkg::HUE_RANGE;
      end
      hue_ofs = nxt;
    end
    return c;
  endfunction

  function automatic void add_cfg(logic [XW-1:0] idx, int unsigned data);
    row_t r;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.data    = data[DW-1:0];
    r.px      = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_pix(int unsigned idx, bit fe, bit typed = 1'b0,
                                  int unsigned red = 0, int unsigned grn = 0,
                                  int unsigned blu = 0, int unsigned hue = 0);
    row_t r;
    r.kind           = ROW_PIX;
    r.reg_idx        = '0;
    r.data           = '0;
    r.px.led_index   = idx[IW-1:0];
    r.px.frame_end   = fe;
    r.typed          = typed;
    r.want.red       = red[CW-1:0];
    r.want.green     = grn[CW-1:0];
    r.want.blue      = blu[CW-1:0];
    r.want.pixel_hue = hue[HW-1:0];
    plan.push_back(r);
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    pix_valid <= 1'b0;
    burst_left = 0;
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [XW-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[DW-1:0];
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data[DW-1:0]);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input rpcg_pkg::pix_t p, input bit typed,
                            input rpcg_pkg::color_t want);
    rpcg_pkg::color_t predicted;
    if (burst_left == 0) begin
      @(negedge clk);
      pix_valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    pix_valid <= 1'b1;
    pix       <= p;
    do @(posedge clk); while (!pix_ready);
    predicted = predict_pixel_color(p);
    pending_colors.push_back(typed ? want : predicted);
    burst_left--;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endtask

  // Receiver: stretches of always ready, random stalls, and mostly stalled.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_left  = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_style)
      0:       color_ready <= 1'b1;
      1:       color_ready <= 1'($urandom_range(0, 1));
      default: color_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((pix_valid && pix_ready) || (color_valid && color_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (color_valid && color_ready) begin
        if (pending_colors.size() == 0) begin
          errors++;
          if (errors <= MAX_PRINTS)
            $display("%0t: color with no request waiting, got %0d %0d %0d hue %0d", $time,
                     color.red, color.green, color.blue, color.pixel_hue);
        end else begin
          oldest = pending_colors.pop_front();
          colors_checked++;
          if (color.red !== oldest.red) check_field("red", oldest.red, color.red);
          if (color.green !== oldest.green) check_field("green", oldest.green, color.green);
          if (color.blue !== oldest.blue) check_field("blue", oldest.blue, color.blue);
          if (color.pixel_hue !== oldest.pixel_hue)
            check_field("pixel_hue", oldest.pixel_hue, color.pixel_hue);
        end
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d colors outstanding", $time,
                 WATCHDOG_LIMIT, pending_colors.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n, pos, len;
    rpcg_pkg::pix_t p;
    rpcg_pkg::color_t none;
    none = '0;
    reset_model();

    // Directed table. Colors are typed in only where they are obvious.
    add_pix(0, 1'b0, 1'b1, 255, 0, 0, 0);
    add_pix(rpcg_pkg::MAX_LEDS - 1, 1'b0);
    add_pix(10, 1'b0);
    add_pix(20, 1'b0);
    add_pix(30, 1'b0);
    add_pix(40, 1'b0);
    add_pix(50, 1'b0);
    add_pix(25, 1'b1);
    add_cfg(rpcg_pkg::REG_BRIGHTNESS, 0);
    add_pix(0, 1'b0, 1'b1, 0, 0, 0, 1);
    add_cfg(rpcg_pkg::REG_BRIGHTNESS, 255);
    add_cfg(rpcg_pkg::REG_SATURATION, 0);
    add_pix(7, 1'b0);
    add_cfg(rpcg_pkg::REG_SATURATION, 255);
    add_cfg(rpcg_pkg::REG_SPEED, 255);
    add_pix(0, 1'b1);
    add_pix(0, 1'b1);
    // The chase offset went past a full turn and must be back at zero.
    add_pix(0, 1'b0, 1'b1, 255, 0, 0, 0);
    add_cfg(rpcg_pkg::REG_MODE, MODE_CYCLE);
    add_pix(3, 1'b1);
    add_pix(3, 1'b1);
    add_pix(0, 1'b0);
    add_cfg(rpcg_pkg::REG_STRIP_LENGTH, 0);
    // Only bit zero of the mode register counts, so this selects chase.
    add_cfg(rpcg_pkg::REG_MODE, DATA_ALL_ONES - 1);
    add_pix(rpcg_pkg::MAX_LEDS - 1, 1'b0);
    add_cfg(rpcg_pkg::REG_STRIP_LENGTH, LEN_ALL_ONES);
    add_pix(rpcg_pkg::MAX_LEDS - 1, 1'b0);
    add_cfg(REG_TOP, 0);
    add_cfg(REG_SPARE, DATA_ALL_ONES);
    add_pix(512, 1'b0);
    add_cfg(rpcg_pkg::REG_STRIP_LENGTH, 1);
    add_pix(1, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].data);
      end else begin
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == 0) begin
        write_reg(rpcg_pkg::REG_MODE, MODE_CYCLE);
        write_reg(rpcg_pkg::REG_SPEED, DATA_ALL_ONES);
        write_reg(rpcg_pkg::REG_STRIP_LENGTH, LEN_ALL_ONES);
        write_reg(rpcg_pkg::REG_SATURATION, DATA_ALL_ONES);
        write_reg(rpcg_pkg::REG_BRIGHTNESS, DATA_ALL_ONES);
      end else if (ph == 1) begin
        write_reg(rpcg_pkg::REG_MODE, MODE_CHASE);
        write_reg(rpcg_pkg::REG_SPEED, 0);
        write_reg(rpcg_pkg::REG_STRIP_LENGTH, 0);
        write_reg(rpcg_pkg::REG_SATURATION, 0);
        write_reg(rpcg_pkg::REG_BRIGHTNESS, 0);
      end else begin
        case ($urandom_range(0, 3))
          0:       len = $urandom_range(1, 16);
          1:       len = $urandom_range(17, rpcg_pkg::MAX_LEDS);
          2:       len = $urandom_range(rpcg_pkg::MAX_LEDS + 1, LEN_ALL_ONES);
          default: begin
            case ($urandom_range(0, 2))
              0:       len = 0;
              1:       len = 1;
              default: len = rpcg_pkg::MAX_LEDS;
            endcase
          end
        endcase
        write_reg(rpcg_pkg::REG_MODE, $urandom_range(0, DATA_ALL_ONES));
        write_reg(rpcg_pkg::REG_SPEED, $urandom_range(0, DATA_ALL_ONES));
        write_reg(rpcg_pkg::REG_STRIP_LENGTH, len);
        write_reg(rpcg_pkg::REG_SATURATION, $urandom_range(0, DATA_ALL_ONES));
        write_reg(rpcg_pkg::REG_BRIGHTNESS, $urandom_range(0, DATA_ALL_ONES));
        if ($urandom_range(0, 2) == 0)
          write_reg(XW'($urandom_range(REG_SPARE, REG_TOP)), $urandom_range(0, DATA_ALL_ONES));
      end

      // Mostly whole frames swept in order, with stray requests mixed in.
      n   = usable_length();
      pos = 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 4) != 0) begin
          if (pos >= n - 1) begin
            p.led_index = IW'(n - 1);
            p.frame_end = 1'b1;
            pos = 0;
          end else begin
            p.led_index = IW'(pos);
            p.frame_end = 1'b0;
            pos += $urandom_range(1, n / 8 + 1);
          end
        end else begin
          p.led_index = IW'($urandom_range(0, rpcg_pkg::MAX_LEDS - 1));
          p.frame_end = 1'($urandom_range(0, 1));
        end
        send_pixel(p, 1'b0, none);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d colors after %0d register writes over %0d random settings,",
             colors_checked, reg_writes, PHASES);
    $display("covering chase and cycle modes, offset wrap, clamped indices and odd lengths.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rpcg_pkg.sv
hw/rtl/rpcg_serial_div.sv
hw/rtl/rpcg_hsv.sv
hw/rtl/rainbow_pixel_color_generator.sv
bench/tb_rainbow_pixel_color_generator.sv
